FILE: sv/mbpu_pkg.sv
// ----------------------------------------------------------------------------
// mbpu_pkg
// Shared types and constants for the MSB-first bit packer / unpacker.
// ----------------------------------------------------------------------------
package mbpu_pkg;

    localparam int STORE_BYTES_DEF = 256;

    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int NBITS_W   = 4;
    localparam int IDX_W     = 9;
    localparam int LEFT_W    = 4;
    localparam int BUF_LEN_W = 9;

    localparam logic [BUF_LEN_W-1:0] BUF_LEN_RST = 9'd256;
    localparam logic [LEFT_W-1:0]    LEFT_FULL   = 4'd8;

    // item kinds; the fourth code is refused
    localparam logic [KIND_W-1:0] KIND_REWIND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUT    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GET    = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIRST,
        S_SECOND
    } t_state;

    typedef struct packed {
        logic accept;     // latch item and precomputed cursor
        logic cap_b0;     // keep first store byte
        logic rd_en;
        logic rd_second;  // read the byte after the cursor byte
        logic wr_en;
        logic wr_second;  // write the byte after the cursor byte
        logic finish;     // load result, update cursor
    } t_cmd;

    typedef struct packed {
        logic span_go;    // accepted field spans two bytes and goes ahead
        logic do_write;   // accepted put that goes ahead
        logic out_free;   // result register can take a new result
    } t_status;

endpackage

FILE: sv/mbpu_ram.sv
// ----------------------------------------------------------------------------
// mbpu_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module mbpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/mbpu_ctrl.sv
// ----------------------------------------------------------------------------
// mbpu_ctrl
// Sequencer: at most one store read per cycle, read-modify-write over up to two bytes.
// ----------------------------------------------------------------------------
module mbpu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mbpu_pkg::t_status i_status,
    output mbpu_pkg::t_cmd    o_cmd
);

    mbpu_pkg::t_state r_state;
    mbpu_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbpu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            mbpu_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    n_state      = mbpu_pkg::S_FIRST;
                end
            end
            mbpu_pkg::S_FIRST: begin
                // store data holds while stalled, since no read is issued
                o_cmd.cap_b0 = 1'b1;
                if (i_status.span_go) begin
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.rd_second = 1'b1;
                    o_cmd.wr_en     = i_status.do_write;
                    n_state         = mbpu_pkg::S_SECOND;
                end else if (i_status.out_free) begin
                    o_cmd.wr_en  = i_status.do_write;
                    o_cmd.finish = 1'b1;
                    n_state      = mbpu_pkg::S_IDLE;
                end
            end
            mbpu_pkg::S_SECOND: begin
                if (i_status.out_free) begin
                    o_cmd.wr_en     = i_status.do_write;
                    o_cmd.wr_second = 1'b1;
                    o_cmd.finish    = 1'b1;
                    n_state         = mbpu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mbpu_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/mbpu_dp.sv
// ----------------------------------------------------------------------------
// mbpu_dp
// Datapath: bit cursor, length register, field shifting and result register.
// ----------------------------------------------------------------------------
module mbpu_dp #(
    parameter int STORE_BYTES = mbpu_pkg::STORE_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mbpu_pkg::t_cmd                     i_cmd,
    output mbpu_pkg::t_status                  o_status,
    input  logic                               i_cfg_we,
    input  logic [mbpu_pkg::BUF_LEN_W-1:0]     i_cfg_wdata,
    input  logic [mbpu_pkg::KIND_W-1:0]        i_kind,
    input  logic [mbpu_pkg::BYTE_W-1:0]        i_bits,
    input  logic [mbpu_pkg::NBITS_W-1:0]       i_nbits,
    output logic                               o_ram_rd_en,
    output logic [$clog2(STORE_BYTES)-1:0]     o_ram_rd_addr,
    input  logic [mbpu_pkg::BYTE_W-1:0]        i_ram_rd_data,
    output logic                               o_ram_wr_en,
    output logic [$clog2(STORE_BYTES)-1:0]     o_ram_wr_addr,
    output logic [mbpu_pkg::BYTE_W-1:0]        o_ram_wr_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [mbpu_pkg::BYTE_W-1:0]        o_read_value,
    output logic [mbpu_pkg::IDX_W-1:0]         o_bytes_used,
    output logic                               o_error
);

    localparam int ADDR_W = $clog2(STORE_BYTES);

    // cursor and length
    logic [mbpu_pkg::IDX_W-1:0]     r_byte_index;
    logic [mbpu_pkg::LEFT_W-1:0]    r_bits_left;
    logic [mbpu_pkg::BUF_LEN_W-1:0] r_buf_len;

    // latched item
    logic [mbpu_pkg::KIND_W-1:0]    r_kind;
    logic [mbpu_pkg::BYTE_W-1:0]    r_bits;
    logic [mbpu_pkg::BYTE_W-1:0]    r_mask;
    logic [mbpu_pkg::BYTE_W-1:0]    r_keep;
    logic [3:0]                     r_sh;
    logic                           r_span;
    logic                           r_err;
    logic [mbpu_pkg::IDX_W:0]       r_idx;
    logic [mbpu_pkg::IDX_W:0]       r_idx_p1;
    logic [mbpu_pkg::IDX_W-1:0]     r_nidx;
    logic [mbpu_pkg::LEFT_W-1:0]    r_nleft;
    logic [mbpu_pkg::BYTE_W-1:0]    r_b0;

    // result
    logic                           r_out_valid;
    logic [mbpu_pkg::BYTE_W-1:0]    r_read_value;
    logic [mbpu_pkg::IDX_W-1:0]     r_bytes_used;
    logic                           r_error;

    // precompute at accept
    logic [mbpu_pkg::IDX_W:0]       cur_idx;
    logic [mbpu_pkg::LEFT_W-1:0]    cur_left;
    logic                           cur_span;
    logic [mbpu_pkg::IDX_W:0]       idx_p1;
    logic [mbpu_pkg::IDX_W:0]       last;
    logic [4:0]                     sh5;
    logic                           width_bad;
    logic                           overrun;
    logic                           acc_err;
    logic [15:0]                    mask16;
    logic [mbpu_pkg::BYTE_W-1:0]    keep;
    logic [mbpu_pkg::LEFT_W-1:0]    nleft;

    // finish
    logic [mbpu_pkg::IDX_W-1:0]     fin_idx;
    logic [mbpu_pkg::LEFT_W-1:0]    fin_left;
    logic [15:0]                    w_get;
    logic [15:0]                    w_put;
    logic [mbpu_pkg::BYTE_W-1:0]    get_val;

    // lazy advance: an exhausted byte is left only when the next field starts
    assign cur_idx   = {1'b0, r_byte_index} +
                       ((r_bits_left == '0) ? 10'd1 : 10'd0);
    assign cur_left  = (r_bits_left == '0) ? mbpu_pkg::LEFT_FULL : r_bits_left;
    assign cur_span  = i_nbits > cur_left;
    assign idx_p1    = cur_idx + 10'd1;
    assign last      = cur_span ? idx_p1 : cur_idx;
    assign sh5       = 5'd8 + {1'b0, cur_left} - {1'b0, i_nbits};
    assign width_bad = (i_nbits == '0) || (i_nbits > 4'd8);
    assign overrun   = (last >= {1'b0, r_buf_len}) ||
                       (32'(last) >= 32'(STORE_BYTES));
    assign mask16    = (16'd1 << i_nbits) - 16'd1;
    assign keep      = 8'hFF << cur_left;
    assign nleft     = cur_span ? sh5[3:0] : (cur_left - i_nbits);

    always_comb begin
        if (i_kind == mbpu_pkg::KIND_REWIND) begin
            acc_err = 1'b0;
        end else if (i_kind == mbpu_pkg::KIND_PUT || i_kind == mbpu_pkg::KIND_GET) begin
            acc_err = width_bad || overrun;
        end else begin
            acc_err = 1'b1;
        end
    end

    always_comb begin
        if (r_kind == mbpu_pkg::KIND_REWIND) begin
            fin_idx  = '0;
            fin_left = mbpu_pkg::LEFT_FULL;
        end else if (r_err) begin
            fin_idx  = r_byte_index;
            fin_left = r_bits_left;
        end else begin
            fin_idx  = r_nidx;
            fin_left = r_nleft;
        end
    end

    // 16-bit window over the cursor byte and the one after it
    assign w_get   = r_span ? {r_b0, i_ram_rd_data} : {i_ram_rd_data, 8'h00};
    assign get_val = 8'(w_get >> r_sh) & r_mask;
    assign w_put   = {i_ram_rd_data & r_keep, 8'h00} | (16'(r_bits & r_mask) << r_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_bits_left  <= mbpu_pkg::LEFT_FULL;
            r_buf_len    <= mbpu_pkg::BUF_LEN_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_buf_len <= i_cfg_wdata;
            end
            if (i_cmd.finish) begin
                r_byte_index <= fin_idx;
                r_bits_left  <= fin_left;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind   <= i_kind;
            r_bits   <= i_bits;
            r_mask   <= mask16[7:0];
            r_keep   <= keep;
            r_sh     <= sh5[3:0];
            r_span   <= cur_span;
            r_err    <= acc_err;
            r_idx    <= cur_idx;
            r_idx_p1 <= idx_p1;
            r_nidx   <= last[mbpu_pkg::IDX_W-1:0];
            r_nleft  <= nleft;
        end
        if (i_cmd.cap_b0) begin
            r_b0 <= i_ram_rd_data;
        end
        if (i_cmd.finish) begin
            r_read_value <= (r_kind == mbpu_pkg::KIND_GET && !r_err) ? get_val : '0;
            r_bytes_used <= fin_idx +
                            ((fin_left != mbpu_pkg::LEFT_FULL) ? 9'd1 : 9'd0);
            r_error      <= r_err;
        end
    end

    assign o_status.span_go  = r_span && !r_err && (r_kind != mbpu_pkg::KIND_REWIND);
    assign o_status.do_write = (r_kind == mbpu_pkg::KIND_PUT) && !r_err;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_ram_rd_en   = i_cmd.rd_en;
    assign o_ram_rd_addr = ADDR_W'(i_cmd.rd_second ? r_idx_p1 : cur_idx);
    assign o_ram_wr_en   = i_cmd.wr_en;
    assign o_ram_wr_addr = ADDR_W'(i_cmd.wr_second ? r_idx_p1 : r_idx);
    assign o_ram_wr_data = i_cmd.wr_second ? w_put[7:0] : w_put[15:8];

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_bytes_used = r_bytes_used;
    assign o_error      = r_error;

endmodule

FILE: sv/msb_first_bit_packer_unpacker_top.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer_unpacker_top
// Packs and unpacks 1..8 bit fields, MSB first, over a byte store.
// ----------------------------------------------------------------------------
// An item whose field lies in one byte, a rewind and a refused item pass
// through S_IDLE and S_FIRST, and the result is registered as it leaves
// S_FIRST. A field that spans two bytes also passes through S_SECOND, and
// its result is registered as it leaves S_SECOND, because the store has one
// read port and the second byte is read (or written) in a cycle of its own.
// A new item can be accepted in the cycle after a result is registered, while
// that result still waits to be taken; a result is held back only if the
// previous one has not left. The store is not cleared after reset, so there
// is no start-up pass: a get of a byte never written returns an undefined
// value. The user must write buf_len only while idle; it is not enforced.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_unpacker_top #(
    parameter int STORE_BYTES = mbpu_pkg::STORE_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mbpu_pkg::BUF_LEN_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [mbpu_pkg::KIND_W-1:0]    i_kind,
    input  logic [mbpu_pkg::BYTE_W-1:0]    i_bits,
    input  logic [mbpu_pkg::NBITS_W-1:0]   i_nbits,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [mbpu_pkg::BYTE_W-1:0]    o_read_value,
    output logic [mbpu_pkg::IDX_W-1:0]     o_bytes_used,
    output logic                           o_error
);

    localparam int ADDR_W = $clog2(STORE_BYTES);

    mbpu_pkg::t_cmd    cmd;
    mbpu_pkg::t_status status;

    logic                        ram_rd_en;
    logic [ADDR_W-1:0]           ram_rd_addr;
    logic [mbpu_pkg::BYTE_W-1:0] ram_rd_data;
    logic                        ram_wr_en;
    logic [ADDR_W-1:0]           ram_wr_addr;
    logic [mbpu_pkg::BYTE_W-1:0] ram_wr_data;

    mbpu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mbpu_dp #(
        .STORE_BYTES (STORE_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_kind        (i_kind),
        .i_bits        (i_bits),
        .i_nbits       (i_nbits),
        .o_ram_rd_en   (ram_rd_en),
        .o_ram_rd_addr (ram_rd_addr),
        .i_ram_rd_data (ram_rd_data),
        .o_ram_wr_en   (ram_wr_en),
        .o_ram_wr_addr (ram_wr_addr),
        .o_ram_wr_data (ram_wr_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_value  (o_read_value),
        .o_bytes_used  (o_bytes_used),
        .o_error       (o_error)
    );

    mbpu_ram #(
        .WIDTH (mbpu_pkg::BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

endmodule

FILE: sv/mbpu_checker.sv
// ----------------------------------------------------------------------------
// mbpu_checker
// Port-level checks for the bit packer / unpacker, bound to the top level.
// ----------------------------------------------------------------------------
module mbpu_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [mbpu_pkg::BYTE_W-1:0]    o_read_value,
    input logic [mbpu_pkg::IDX_W-1:0]     o_bytes_used,
    input logic                           o_error
);

    // no result straight out of reset
    assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // one item in flight: input side closes after a transfer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in flight");

    // a refused item reads nothing
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error) |-> (o_read_value == '0))
        else $error("refused item carries a read value");

    // cursor never reaches past the largest store length
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_bytes_used <= 9'd256))
        else $error("bytes used out of range");

    // stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_read_value) && $stable(o_bytes_used) &&
             $stable(o_error)))
        else $error("stalled result changed");

endmodule

bind msb_first_bit_packer_unpacker_top mbpu_checker u_checker (.*);

FILE: sim/msb_first_bit_packer_unpacker_top_tb.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer_unpacker_top_tb
// Self-checking bench for the MSB-first bit packer / unpacker. A directed
// table covers rewinds, refused widths and kinds, and a field written and
// read back across byte boundaries. Random phases then fill the store to
// overrun, read it back, and mix puts, gets and noise under several store
// lengths and handshake idling patterns. Every result is checked against the
// typed table value or a local model of the store and cursor.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_unpacker_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mbpu_pkg::*;

    localparam int STORE_BYTES = STORE_BYTES_DEF;
    localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam int HOLD_CYCLES = 300;
    localparam int DIR_ROWS    = 23;

    // idle percentages per phase
    localparam int PCT_OFF  = 0;
    localparam int PCT_ONE  = 51;
    localparam int PCT_BOTH = 19;

    typedef struct packed {
        logic [BYTE_W-1:0] read_value;
        logic [IDX_W-1:0]  bytes_used;
        logic              error;
    } t_result;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  bits;
        logic [NBITS_W-1:0] nbits;
        logic               typed;
        t_result            want;
    } t_stim_row;

    // bytes 0..4 end up holding FF 55 EF F0 00; rows 6..11 and 14..21
    // are left to the model
    localparam t_stim_row STIM_TABLE [DIR_ROWS] = '{
        '{KIND_REWIND, 8'h00, 4'd0,  1'b1, '{8'h00, 9'd0, 1'b0}},
        '{KIND_PUT,    8'hFF, 4'd0,  1'b1, '{8'h00, 9'd0, 1'b1}},
        '{KIND_PUT,    8'hFF, 4'd15, 1'b1, '{8'h00, 9'd0, 1'b1}},
        '{KIND_BAD,    8'h5A, 4'd4,  1'b1, '{8'h00, 9'd0, 1'b1}},
        '{KIND_GET,    8'h00, 4'd9,  1'b1, '{8'h00, 9'd0, 1'b1}},
        '{KIND_PUT,    8'hFF, 4'd8,  1'b1, '{8'h00, 9'd1, 1'b0}},
        '{KIND_PUT,    8'h00, 4'd1,  1'b0, '{8'h00, 9'd0, 1'b0}},
        '{KIND_PUT,    8'hAB, 4'd8,  1'b0, '{8'h00, 9'd0, 1'b0}},
        '{KIND_PUT,    8'h01, 4'd1,  1'b0, '{8'h00, 9'd0, 1'b0}},
        '{KIND_PUT,    8'hFD, 4'd3,  1'b0, '{8'h00, 9'd0, 1'b0}},
        '{KIND_PUT,    8'hFF, 4'd7,  1'b0, '{8'h00, 9'd0, 1'b0}},
        '{KIND_PUT,    8'h00, 4'd8,  1'b0, '{8'h00, 9'd0, 1'b0}},
        '{KIND_REWIND, 8'hFF, 4'd15, 1'b1, '{8'h00, 9'd0, 1'b0}},
        '{KIND_GET,    8'h00, 4'd8,  1'b1, '{8'hFF, 9'd1, 1'b0}},
        '{KIND_GET,    8'h00, 4'd1,  1'b0, '{8'h00, 9'd0, 1'b0}},
        '{KIND_GET,    8'h00, 4'd8,  1'b0, '{8'h00, 9'd0, 1'b0}},
        '{KIND_GET,    8'h00, 4'd1,  1'b0, '{8'h00, 9'd0, 1'b0}},
        '{KIND_GET,    8'h00, 4'd3,  1'b0, '{8'h00, 9'd0, 1'b0}},
        '{KIND_GET,    8'h00, 4'd7,  1'b0, '{8'h00, 9'd0, 1'b0}},
        '{KIND_GET,    8'h00, 4'd8,  1'b0, '{8'h00, 9'd0, 1'b0}},
        '{KIND_GET,    8'hFF, 4'd4,  1'b0, '{8'h00, 9'd0, 1'b0}},
        '{KIND_BAD,    8'h00, 4'd8,  1'b0, '{8'h00, 9'd0, 1'b0}},
        '{KIND_REWIND, 8'h00, 4'd0,  1'b1, '{8'h00, 9'd0, 1'b0}}
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [BUF_LEN_W-1:0] i_cfg_wdata = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic [KIND_W-1:0]    i_kind      = '0;
    logic [BYTE_W-1:0]    i_bits      = '0;
    logic [NBITS_W-1:0]   i_nbits     = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [BYTE_W-1:0]    o_read_value;
    logic [IDX_W-1:0]     o_bytes_used;
    logic                 o_error;

    // local copy of store, cursor and length
    logic [BYTE_W-1:0]    shadow_store   [STORE_BYTES];
    bit                   shadow_written [STORE_BYTES];
    logic [IDX_W-1:0]     shadow_index = '0;
    logic [LEFT_W-1:0]    shadow_left  = LEFT_FULL;
    logic [BUF_LEN_W-1:0] shadow_len   = BUF_LEN_RST;

    t_result expected_results [$];
    int      fault_count = 0;
    int      snd_pct     = PCT_OFF;
    int      rcv_pct     = PCT_OFF;
    int      hold_budget = 0;
    int      idle_cycles = 0;

    msb_first_bit_packer_unpacker_top #(
        .STORE_BYTES (STORE_BYTES)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_bits       (i_bits),
        .i_nbits      (i_nbits),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_value (o_read_value),
        .o_bytes_used (o_bytes_used),
        .o_error      (o_error)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Cursor after the lazy advance; returns 1 if the field fits in the store.
    function automatic bit locate_field(input int n, output int idx, output int left,
                                        output bit span);
        int limit;
        limit = (int'(shadow_len) < STORE_BYTES) ? int'(shadow_len) : STORE_BYTES;
        idx   = int'(shadow_index);
        left  = int'(shadow_left);
        if (left == 0) begin
            idx++;
            left = 8;
        end
        span = n > left;
        return ((span ? idx + 1 : idx) < limit);
    endfunction

    // A get that goes ahead must only touch bytes already written.
    function automatic bit get_is_safe(input logic [NBITS_W-1:0] nbits);
        int idx, left;
        bit span;
        if (nbits == 0 || nbits > 8) return 1'b1;
        if (!locate_field(int'(nbits), idx, left, span)) return 1'b1;
        return shadow_written[idx] && (!span || shadow_written[idx + 1]);
    endfunction

    function automatic t_result pack_predict(input logic [KIND_W-1:0] kind,
                                             input logic [BYTE_W-1:0] bits,
                                             input logic [NBITS_W-1:0] nbits);
        t_result res;
        int idx, left, n, sh, mask, w;
        bit span;
        logic [BYTE_W-1:0] b0, b1, keep;
        res = '0;
        n   = int'(nbits);
        if (kind == KIND_REWIND) begin
            shadow_index = '0;
            shadow_left  = LEFT_FULL;
        end else if (kind == KIND_BAD || n == 0 || n > 8) begin
            res.error = 1'b1;
        end else if (!locate_field(n, idx, left, span)) begin
            res.error = 1'b1;
        end else begin
            mask = (1 << n) - 1;
            sh   = 8 + left - n;    // field offset within the 16-bit window
            b0   = shadow_store[idx];
            b1   = span ? shadow_store[idx + 1] : 8'h00;
            if (kind == KIND_GET) begin
                res.read_value = 8'((int'({b0, b1}) >> sh) & mask);
            end else begin
                keep = 8'hFF << left;
                w = (int'(b0 & keep) << 8) | ((int'(bits) & mask) << sh);
                shadow_store[idx]   = w[15:8];
                shadow_written[idx] = 1'b1;
                if (span) begin
                    shadow_store[idx + 1]   = w[7:0];
                    shadow_written[idx + 1] = 1'b1;
                end
            end
            if (span) begin
                idx++;
                left = 8 - (n - left);
            end else begin
                left -= n;
            end
            shadow_index = IDX_W'(idx);
            shadow_left  = LEFT_W'(left);
        end
        res.bytes_used = IDX_W'(int'(shadow_index) + ((shadow_left != LEFT_FULL) ? 1 : 0));
        return res;
    endfunction

    task automatic drive_item(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] bits,
                              input logic [NBITS_W-1:0] nbits, input t_result want);
        expected_results.push_back(want);
        while ($urandom_range(0, 99) < snd_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_bits     <= bits;
        i_nbits    <= nbits;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    // Drain, then write the length while the block is idle.
    task automatic begin_phase(input logic [BUF_LEN_W-1:0] len, input int snd, input int rcv);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        shadow_len = len;
        snd_pct    = snd;
        rcv_pct    = rcv;
    endtask

    task automatic run_mixed(input int count, input int rewind_pct);
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  bits;
        logic [NBITS_W-1:0] nbits;
        int roll;
        repeat (count) begin
            roll  = $urandom_range(0, 99);
            bits  = BYTE_W'($urandom);
            nbits = NBITS_W'($urandom_range(1, 8));
            if (roll < rewind_pct) begin
                kind  = KIND_REWIND;
                nbits = NBITS_W'($urandom);
            end else if (roll < rewind_pct + 6) begin
                if ($urandom_range(0, 2) == 0) begin
                    kind  = KIND_BAD;
                    nbits = NBITS_W'($urandom);
                end else begin
                    kind  = $urandom_range(0, 1) ? KIND_PUT : KIND_GET;
                    nbits = NBITS_W'($urandom_range(8, 15));
                    if (nbits == 8) nbits = 0;
                end
            end else if (roll < 55) begin
                kind = KIND_PUT;
            end else begin
                kind = get_is_safe(nbits) ? KIND_GET : KIND_PUT;
            end
            drive_item(kind, bits, nbits, pack_predict(kind, bits, nbits));
        end
    endtask

    // Pack random fields until the store overruns, then read it all back.
    task automatic fill_and_read_back();
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  bits;
        logic [NBITS_W-1:0] nbits;
        t_result res;
        int refused;
        for (int pass = 0; pass < 2; pass++) begin
            drive_item(KIND_REWIND, 8'h00, 4'd0, pack_predict(KIND_REWIND, 8'h00, 4'd0));
            refused = 0;
            while (refused < 3) begin
                bits  = BYTE_W'($urandom);
                nbits = NBITS_W'($urandom_range(1, 8));
                kind  = (pass == 0 || !get_is_safe(nbits)) ? KIND_PUT : KIND_GET;
                res   = pack_predict(kind, bits, nbits);
                if (res.error) refused++;
                drive_item(kind, bits, nbits, res);
            end
        end
    endtask

    // receiver; a requested hold-off is counted down here
    always @(posedge i_clk) begin
        if (hold_budget > 0) begin
            hold_budget--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= rcv_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing pending");
                fault_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_read_value !== want.read_value) begin
                    $error("read_value: expected %0h, got %0h", want.read_value, o_read_value);
                    fault_count++;
                end
                if (o_bytes_used !== want.bytes_used) begin
                    $error("bytes_used: expected %0d, got %0d", want.bytes_used, o_bytes_used);
                    fault_count++;
                end
                if (o_error !== want.error) begin
                    $error("error: expected %0b, got %0b", want.error, o_error);
                    fault_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("msb_first_bit_packer_unpacker_top regression: fail");
            $finish;
        end
    end

    initial begin
        t_result pred;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        begin_phase(BUF_LEN_RST, PCT_OFF, PCT_OFF);
        foreach (STIM_TABLE[i]) begin
            pred = pack_predict(STIM_TABLE[i].kind, STIM_TABLE[i].bits, STIM_TABLE[i].nbits);
            drive_item(STIM_TABLE[i].kind, STIM_TABLE[i].bits, STIM_TABLE[i].nbits,
                       STIM_TABLE[i].typed ? STIM_TABLE[i].want : pred);
        end

        begin_phase(BUF_LEN_RST, PCT_ONE, PCT_OFF);
        fill_and_read_back();
        // length shrinks below the cursor left by the fill
        begin_phase(9'd0, PCT_OFF, PCT_ONE);
        run_mixed(80, 10);
        begin_phase(9'd1, PCT_BOTH, PCT_BOTH);
        run_mixed(120, 10);
        begin_phase(9'd2, PCT_OFF, PCT_OFF);
        run_mixed(120, 8);
        begin_phase(BUF_LEN_W'($urandom_range(3, 40)), PCT_ONE, PCT_OFF);
        run_mixed(180, 4);
        // long output hold-off while items keep coming
        begin_phase(BUF_LEN_RST, PCT_OFF, PCT_ONE);
        hold_budget = HOLD_CYCLES;
        run_mixed(180, 2);
        begin_phase(BUF_LEN_W'($urandom_range(0, STORE_BYTES)), PCT_BOTH, PCT_BOTH);
        run_mixed(170, 4);

        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("msb_first_bit_packer_unpacker_top regression: pass");
        end else begin
            $display("msb_first_bit_packer_unpacker_top regression: fail");
        end
        $finish;
    end

endmodule
